// ===== rtl/core/fcu_pkg.sv =====
// Package for the frustum culling unit: item kinds, controller states,
// command and status structs shared by the controller and the datapath.
`timescale 1ns / 1ps
package fcu_pkg;

  localparam int FRAC_BITS = 16;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_VERTEX = 2'd1,
    KIND_SPHERE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAW,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_STORE,
    ST_DOT,
    ST_EVAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       sphere_sel;
    logic       load_matrix;
    logic       raw_start;
    logic       sq_step;
    logic       sqrt_start;
    logic       div_start;
    logic       store_comp;
    logic       dot_step;
    logic       eval_plane;
    logic       mask_reset;
    logic [2:0] plane;
    logic [1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
  } stat_t;

endpackage

// ===== rtl/core/fcu_ctrl.sv =====
// Controller for the frustum culling unit: sequences plane building and
// plane tests. Depends on fcu_pkg.
`timescale 1ns / 1ps
module fcu_ctrl
  import fcu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  input  logic       in_last,
  output logic       in_ready,
  output logic       res_push,
  input  logic       res_free,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t     state, state_next;
  logic [2:0] plane, plane_next;
  logic [1:0] comp, comp_next;
  logic       stale, stale_next;
  logic [1:0] kind, kind_next;
  logic       last, last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      plane <= '0;
      comp  <= '0;
      stale <= 1'b1;
      kind  <= KIND_NONE;
      last  <= 1'b0;
    end else begin
      state <= state_next;
      plane <= plane_next;
      comp  <= comp_next;
      stale <= stale_next;
      kind  <= kind_next;
      last  <= last_next;
    end
  end

  always_comb begin
    state_next = state;
    plane_next = plane;
    comp_next  = comp;
    stale_next = stale;
    kind_next  = kind;
    last_next  = last;
    cmd        = '0;
    cmd.plane  = plane;
    cmd.comp   = comp;
    in_ready   = 1'b0;
    res_push   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = res_free;
        if (in_valid && res_free) begin
          cmd.capture    = 1'b1;
          cmd.sphere_sel = (kind_t'(in_kind) == KIND_SPHERE);
          kind_next      = in_kind;
          last_next      = in_last;
          plane_next     = '0;
          comp_next      = '0;
          case (kind_t'(in_kind))
            KIND_LOAD: begin
              cmd.load_matrix = 1'b1;
              stale_next      = 1'b1;
            end
            KIND_VERTEX, KIND_SPHERE: state_next = stale ? ST_RAW : ST_DOT;
            default: ;
          endcase
        end
      end
      ST_RAW: begin
        cmd.raw_start = 1'b1;
        comp_next     = '0;
        state_next    = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq_step = 1'b1;
        comp_next   = comp + 2'd1;
        if (comp == 2'd2) begin
          comp_next  = '0;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_start = (comp == 2'd0);
        comp_next      = 2'd1;
        if (stat.sqrt_done && comp == 2'd1) begin
          comp_next  = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = ST_STORE;
      end
      ST_STORE: begin
        if (stat.div_done) begin
          cmd.store_comp = 1'b1;
          comp_next      = comp + 2'd1;
          if (comp == 2'd3) begin
            comp_next = '0;
            if (plane == 3'd5) begin
              plane_next = '0;
              stale_next = 1'b0;
              state_next = ST_DOT;
            end else begin
              plane_next = plane + 3'd1;
              state_next = ST_RAW;
            end
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DOT: begin
        cmd.dot_step = 1'b1;
        comp_next    = comp + 2'd1;
        if (comp == 2'd3) begin
          comp_next  = '0;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval_plane = 1'b1;
        if (plane == 3'd5) begin
          plane_next = '0;
          state_next = ST_OUT;
        end else begin
          plane_next = plane + 3'd1;
          state_next = ST_DOT;
        end
      end
      ST_OUT: begin
        if (kind == KIND_SPHERE || last) begin
          res_push       = 1'b1;
          cmd.mask_reset = (kind == KIND_VERTEX);
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/fcu_datapath.sv =====
// Datapath for the frustum culling unit: matrix and plane stores, a squaring
// multiplier, a dot-product multiplier, an iterative square root and divider. Depends on fcu_pkg.
`timescale 1ns / 1ps
module fcu_datapath
  import fcu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [3:0]         in_index,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic [30:0]        in_radius,
  output logic               vis
);

  logic signed [31:0] matrix [16];
  logic signed [31:0] planes [24];
  logic signed [31:0] px, py, pz;
  logic [30:0]        rad;
  logic               sphere;
  logic [5:0]         mask;
  logic               sphere_vis;

  logic signed [32:0] raw [4];
  logic [71:0]        sum_sq;
  logic [35:0]        len;

  // plane row and sign
  logic [1:0] prow;
  logic       pminus;
  always_comb begin
    case (cmd.plane)
      3'd0: begin prow = 2'd0; pminus = 1'b1; end
      3'd1: begin prow = 2'd0; pminus = 1'b0; end
      3'd2: begin prow = 2'd1; pminus = 1'b0; end
      3'd3: begin prow = 2'd1; pminus = 1'b1; end
      3'd4: begin prow = 2'd2; pminus = 1'b1; end
      default: begin prow = 2'd2; pminus = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) matrix[i] <= '0;
    end else if (cmd.load_matrix) begin
      matrix[in_index] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px     <= in_x;
      py     <= in_y;
      pz     <= in_z;
      rad    <= in_radius;
      sphere <= cmd.sphere_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.raw_start) begin
      for (int j = 0; j < 4; j++) begin
        raw[j] <= pminus
          ? {matrix[j*4+3][31], matrix[j*4+3]} - {matrix[j*4+prow][31], matrix[j*4+prow]}
          : {matrix[j*4+3][31], matrix[j*4+3]} + {matrix[j*4+prow][31], matrix[j*4+prow]};
      end
    end
  end

  // squares, one per cycle
  logic [32:0] sq_mag;
  logic [65:0] sq_val;
  assign sq_mag = raw[cmd.comp][32] ? 33'(-raw[cmd.comp]) : 33'(raw[cmd.comp]);
  assign sq_val = sq_mag * sq_mag;

  always_ff @(posedge clk) begin
    if (cmd.raw_start) sum_sq <= '0;
    else if (cmd.sq_step) sum_sq <= sum_sq + 72'(sq_val);
  end

  // square root, one bit a cycle (restoring)
  logic [71:0] sq_rem;
  logic [35:0] sq_root;
  logic [5:0]  sq_cnt;
  logic        sq_busy;
  logic [73:0] sq_trial;
  logic [73:0] sq_cur;
  logic [71:0] rad_sh;
  always_comb begin
    sq_cur   = {sq_rem, rad_sh[71:70]};
    sq_trial = sq_cur - {36'd0, sq_root, 2'b01};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_cnt  <= '0;
    end else if (cmd.sqrt_start) begin
      sq_busy <= 1'b1;
      sq_cnt  <= 6'd36;
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (sq_busy) begin
      if (!sq_trial[73]) begin
        sq_rem  <= sq_trial[71:0];
        sq_root <= {sq_root[34:0], 1'b1};
      end else begin
        sq_rem  <= sq_cur[71:0];
        sq_root <= {sq_root[34:0], 1'b0};
      end
      sq_cnt <= sq_cnt - 6'd1;
      if (sq_cnt == 6'd1) sq_busy <= 1'b0;
    end
  end
  // shift the radicand alongside the square root iteration
  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) rad_sh <= sum_sq;
    else if (sq_busy) rad_sh <= {rad_sh[69:0], 2'b00};
  end
  assign stat.sqrt_done = !sq_busy;
  always_ff @(posedge clk) begin
    if (sq_busy && sq_cnt == 6'd1) len <= !sq_trial[73] ? {sq_root[34:0], 1'b1}
                                                        : {sq_root[34:0], 1'b0};
  end

  // divider: (|a| << F) / len, one quotient bit a cycle
  localparam int NUM_W = 33 + FRAC_BITS;
  logic [NUM_W-1:0] dv_num;
  logic [NUM_W-1:0] dv_q;
  logic [36:0]      dv_rem;
  logic [6:0]       dv_cnt;
  logic             dv_busy;
  logic             dv_neg;
  logic [36:0]      dv_sh;
  logic [36:0]      dv_sub;
  always_comb begin
    dv_sh  = {dv_rem[35:0], dv_num[NUM_W-1]};
    dv_sub = dv_sh - {1'b0, len};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_cnt  <= '0;
    end else if (cmd.div_start) begin
      dv_busy <= 1'b1;
      dv_cnt  <= 7'(NUM_W);
      dv_neg  <= raw[cmd.comp][32];
      dv_num  <= {(raw[cmd.comp][32] ? 33'(-raw[cmd.comp]) : 33'(raw[cmd.comp])),
                  {FRAC_BITS{1'b0}}};
      dv_rem  <= '0;
      dv_q    <= '0;
    end else if (dv_busy) begin
      dv_num <= {dv_num[NUM_W-2:0], 1'b0};
      if (!dv_sub[36]) begin
        dv_rem <= dv_sub;
        dv_q   <= {dv_q[NUM_W-2:0], 1'b1};
      end else begin
        dv_rem <= dv_sh;
        dv_q   <= {dv_q[NUM_W-2:0], 1'b0};
      end
      dv_cnt <= dv_cnt - 7'd1;
      if (dv_cnt == 7'd1) dv_busy <= 1'b0;
    end
  end
  assign stat.div_done = !dv_busy;

  // saturate the signed quotient to 32 bits
  logic [31:0] comp_val;
  always_comb begin
    if (len == '0) comp_val = '0;
    else if (dv_neg) comp_val = (dv_q > NUM_W'(32'h8000_0000)) ? 32'h8000_0000
                                                             : 32'(-dv_q);
    else comp_val = (dv_q > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : dv_q[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 24; i++) planes[i] <= '0;
    end else if (cmd.store_comp) begin
      planes[{cmd.plane, cmd.comp}] <= comp_val;
    end
  end

  // plane distance, one product a cycle
  logic signed [31:0] dot_a;
  logic signed [32:0] dot_b;
  logic signed [64:0] dot_p;
  logic signed [67:0] acc;
  always_comb begin
    dot_a = planes[5'({cmd.plane, 2'b00}) + 5'(cmd.comp)];
    case (cmd.comp)
      2'd0: dot_b = 33'(px);
      2'd1: dot_b = 33'(py);
      2'd2: dot_b = 33'(pz);
      default: dot_b = sphere ? 33'({rad, 1'b0}) >>> 1 : 33'(0);
    endcase
    dot_p = dot_a * dot_b;
  end
  logic signed [67:0] pdist;
  always_comb begin
    pdist = acc + (68'(planes[5'({cmd.plane, 2'b00}) + 5'd3]) <<< FRAC_BITS);
    if (sphere) pdist = pdist + (68'({1'b0, rad}) <<< FRAC_BITS);
  end
  always_ff @(posedge clk) begin
    if (cmd.dot_step) begin
      if (cmd.comp == 2'd0) acc <= 68'(dot_p);
      else if (cmd.comp != 2'd3) acc <= acc + 68'(dot_p);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      mask       <= 6'h3F;
      sphere_vis <= 1'b1;
    end else begin
      if (cmd.capture) begin
        sphere_vis <= 1'b1;
      end
      if (cmd.eval_plane) begin
        if (sphere) begin
          if (pdist < 0) sphere_vis <= 1'b0;
        end else if (!(acc + (68'(planes[5'({cmd.plane, 2'b00}) + 5'd3]) <<< FRAC_BITS)
                       < 0)) begin
          mask[cmd.plane] <= 1'b0;
        end
      end
      if (cmd.mask_reset) mask <= 6'h3F;
    end
  end
  assign vis = sphere ? sphere_vis : (mask == 6'd0);

endmodule

// ===== rtl/core/frustum_culling_unit.sv =====
// Top level of the frustum culling unit: stream ports, controller and
// datapath. Depends on fcu_pkg, fcu_ctrl and fcu_datapath.
`timescale 1ns / 1ps
// Frustum culling unit. Load transfers write matrix elements; vertex and
// sphere transfers are tested against six normalized frustum planes. When
// planes are current a vertex or sphere goes through an accept step, then
// for each of the six planes a multiply step per plane component plus an
// evaluate step through the shared dot-product multiplier, then an output
// step; the next transfer is taken only after that output step.
// After a matrix load the first test first rebuilds the planes through
// the bit-serial square root and divider. A load transfer is written to the
// matrix as it is accepted. One result transfer is held in an output
// register until taken; input stalls while it waits.
module frustum_culling_unit
  import fcu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: matrix_index[3:0], matrix_value[35:4], point_x[67:36],
  // point_y[99:68], point_z[131:100], sphere_radius[162:132], zero pad
  input  logic [167:0] s_tdata,
  // tuser: kind
  input  logic [1:0]   s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: visible[0], zero pad
  output logic [7:0]   m_tdata
);

  cmd_t  cmd;
  stat_t stat;
  logic  res_push;
  logic  vis;
  logic  out_full;

  fcu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .res_push (res_push),
    .res_free (!out_full || m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fcu_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_index  (s_tdata[3:0]),
    .in_value  (s_tdata[35:4]),
    .in_x      (s_tdata[67:36]),
    .in_y      (s_tdata[99:68]),
    .in_z      (s_tdata[131:100]),
    .in_radius (s_tdata[162:132]),
    .vis       (vis)
  );

  // Hold the result until the master side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_push) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) m_tdata <= {7'd0, vis};
  end

  assign m_tvalid = out_full;

endmodule

// ===== verif/tb_frustum_culling_unit.sv =====
// Testbench for frustum_culling_unit: random and directed stream traffic, checked
// against a built-in plane-extraction and culling predictor.
// Depends on fcu_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_frustum_culling_unit;
  import fcu_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    kind_t       kind;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [31:0] px, py, pz;
    logic [30:0] rad;
    logic        last;
  } cull_item_t;

  // Culling predictor: keeps its own matrix, planes and behind mask, and
  // queues the visibility that each transfer should produce.
  class cull_scoreboard;
    logic signed [31:0] mat[16];
    logic signed [31:0] pln[24];
    bit                 stale;
    bit [5:0]           behind_all;
    bit                 vis_q[$];

    function new();
      foreach (mat[i]) mat[i] = '0;
      foreach (pln[i]) pln[i] = '0;
      stale = 1;
      behind_all = 6'h3f;
    endfunction

    function automatic logic [35:0] root(logic [71:0] s);
      logic [35:0] res, cand;
      res = '0;
      for (int b = 35; b >= 0; b--) begin
        cand = res | (36'd1 << b);
        if ({36'd0, cand} * {36'd0, cand} <= s) res = cand;
      end
      return res;
    endfunction

    function automatic void rebuild();
      int row[6] = '{0, 0, 1, 1, 2, 2};
      bit neg[6] = '{1, 0, 0, 1, 1, 0};
      logic signed [33:0] raw[4];
      logic [33:0]        mag;
      logic [71:0]        sum;
      logic [35:0]        len;
      logic [63:0]        q;
      logic signed [65:0] v;
      for (int p = 0; p < 6; p++) begin
        sum = '0;
        for (int j = 0; j < 4; j++) begin
          raw[j] = neg[p] ? 34'(mat[j*4+3]) - 34'(mat[j*4+row[p]])
                          : 34'(mat[j*4+3]) + 34'(mat[j*4+row[p]]);
          mag = raw[j][33] ? 34'(-raw[j]) : raw[j];
          if (j < 3) sum += {38'd0, mag} * {38'd0, mag};
        end
        len = root(sum);
        for (int j = 0; j < 4; j++) begin
          v = '0;
          if (len != 0) begin
            mag = raw[j][33] ? 34'(-raw[j]) : raw[j];
            q = ({30'd0, mag} << FRAC_BITS) / {28'd0, len};
            v = raw[j][33] ? -$signed({2'b0, q}) : $signed({2'b0, q});
            if (v > 66'sh7fffffff) v = 66'sh7fffffff;
            if (v < -66'sh80000000) v = -66'sh80000000;
          end
          pln[p*4+j] = v[31:0];
        end
      end
      stale = 0;
    endfunction

    function automatic logic signed [71:0] plane_dist(int p, cull_item_t it);
      return 72'(pln[p*4]) * 72'($signed(it.px)) + 72'(pln[p*4+1]) * 72'($signed(it.py))
           + 72'(pln[p*4+2]) * 72'($signed(it.pz))
           + (72'(pln[p*4+3]) <<< FRAC_BITS);
    endfunction

    function automatic void note_input(cull_item_t it);
      bit [5:0] behind;
      bit       vis;
      logic signed [71:0] r;
      if (it.kind == KIND_LOAD) begin
        mat[it.idx] = it.val;
        stale = 1;
        return;
      end
      if (it.kind == KIND_NONE) return;
      if (stale) rebuild();
      if (it.kind == KIND_VERTEX) begin
        behind = '0;
        for (int p = 0; p < 6; p++) if (plane_dist(p, it) < 0) behind[p] = 1;
        behind_all &= behind;
        if (it.last) begin
          vis_q.push_back(behind_all == 0);
          behind_all = 6'h3f;
        end
      end else begin
        r = 72'({1'b0, it.rad}) <<< FRAC_BITS;
        vis = 1;
        for (int p = 0; p < 6; p++) if (plane_dist(p, it) + r < 0) vis = 0;
        vis_q.push_back(vis);
      end
    endfunction

    // Returns 0 when ok, 1 when nothing was expected, 2 on a wrong value.
    function automatic int check(logic vis, output bit want);
      want = 0;
      if (vis_q.size() == 0) return 1;
      want = vis_q.pop_front();
      return (vis === want) ? 0 : 2;
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         s_tlast = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [7:0]   m_tdata;

  cull_scoreboard sb = new();
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;

  frustum_culling_unit u_top (.*);

  always begin
    #CLK_HALF clk = 1;
    #CLK_HALF clk = 0;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report(string what);
    errors++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  // Put one item on the slave side after a random gap, hold it until taken.
  task automatic push_item(cull_item_t it);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= it.kind;
    s_tlast  <= it.last;
    s_tdata  <= {5'd0, it.rad, it.pz, it.py, it.px, it.val, it.idx};
    do @(posedge clk); while (!s_tready);
    sb.note_input(it);
  endtask

  // Drain results with random stalls and check each one.
  initial begin
    int gap;
    int st;
    bit want;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
      results_seen++;
      st = sb.check(m_tdata[0], want);
      if (st == 1) report("result with nothing expected");
      else if (st == 2) report($sformatf("visible %0b, expected %0b", m_tdata[0], want));
    end
  end

  function automatic cull_item_t blank(kind_t k);
    cull_item_t it;
    it.kind = k;
    it.idx = 4'($urandom);
    it.val = $urandom;
    it.px = $urandom;
    it.py = $urandom;
    it.pz = $urandom;
    it.rad = 31'($urandom);
    it.last = 1'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
    endcase
  endfunction

  task automatic load(int i, logic [31:0] v);
    cull_item_t it;
    it = blank(KIND_LOAD);
    it.idx = 4'(i);
    it.val = v;
    push_item(it);
  endtask

  task automatic vertex(logic [31:0] x, y, z, logic last);
    cull_item_t it;
    it = blank(KIND_VERTEX);
    it.px = x; it.py = y; it.pz = z; it.last = last;
    push_item(it);
  endtask

  task automatic sphere(logic [31:0] x, y, z, logic [30:0] r);
    cull_item_t it;
    it = blank(KIND_SPHERE);
    it.px = x; it.py = y; it.pz = z; it.rad = r;
    push_item(it);
  endtask

  // Load a full matrix; small entries make planes that really cull.
  task automatic random_matrix();
    for (int i = 0; i < 16; i++)
      load(i, $urandom_range(0, 4) == 0 ? $urandom
              : 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000));
  endtask

  initial begin
    int n;
    int wait_cycles;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Zero matrix: every normal has zero length, nothing culls.
    sphere(32'h80000000, 32'h7fffffff, 32'h0, 31'h0);
    vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1);
    push_item(blank(KIND_NONE));
    // Unit box frustum: identity matrix.
    for (int i = 0; i < 16; i++) load(i, (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
    vertex(32'h0, 32'h0, 32'h0, 1);
    vertex(32'h0005_0000, 32'h0, 32'h0, 0);
    vertex(32'h0006_0000, 32'h0001_0000, 32'h0, 1);
    vertex(32'h7fffffff, 32'h0, 32'h0, 0);
    vertex(32'h80000000, 32'h0, 32'h0, 1);
    sphere(32'h0003_0000, 32'h0, 32'h0, 31'h0001_0000);
    sphere(32'h0003_0000, 32'h0, 32'h0, 31'h0002_0000);
    sphere(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff);
    // Load in the middle of a hull keeps the earlier marks.
    vertex(32'h0004_0000, 32'h0, 32'h0, 0);
    load(12, 32'h0003_0000);
    vertex(32'h0004_0000, 32'h0, 32'h0, 1);
    // Huge offset with a tiny normal: d saturates.
    for (int i = 0; i < 16; i++) load(i, 32'h0);
    load(3, 32'h1);
    load(15, 32'h7fffffff);
    sphere(32'h0, 32'h0, 32'h0, 31'h0);
    vertex(32'h80000000, 32'h7fffffff, 32'h0, 1);

    // Random phases: a fresh matrix, then hulls and spheres against it.
    n = 0;
    while (n < 350) begin
      random_matrix();
      n += 16;
      for (int t = 0; t < 40; t++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            sphere(coord(), coord(), coord(),
                   $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h30000)));
            n++;
          end
          3: begin
            push_item(blank(KIND_NONE));
          end
          4: begin
            if ($urandom_range(0, 3) == 0) begin
              load($urandom_range(0, 15), $urandom);
              n++;
            end
          end
          default: begin
            int nv;
            nv = $urandom_range(1, 8);
            for (int v = 0; v < nv; v++) vertex(coord(), coord(), coord(), v == nv - 1);
            n += nv;
          end
        endcase
      end
    end
    s_tvalid <= 0;

    wait_cycles = 0;
    while (sb.vis_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && sb.vis_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.vis_q.size() != 0) report("expected results never arrived");
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fcu_pkg.sv
rtl/core/fcu_ctrl.sv
rtl/core/fcu_datapath.sv
rtl/core/frustum_culling_unit.sv
verif/tb_frustum_culling_unit.sv
